// ===== design/jmbs_pkg.sv =====
// Package with the types, constants and character classes of the JSON message splitter.
package jmbs_pkg;

   localparam int unsigned DEPTH_BITS = 16;
   localparam int unsigned LEN_BITS = 16;
   localparam int unsigned CONSUMED_BITS = 16;
   localparam int unsigned HEX_DIGITS = 4;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_OPEN = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LC_B = 8'h62;
   localparam logic [7:0] CH_LC_F = 8'h66;
   localparam logic [7:0] CH_LC_N = 8'h6E;
   localparam logic [7:0] CH_LC_R = 8'h72;
   localparam logic [7:0] CH_LC_T = 8'h74;
   localparam logic [7:0] CH_LC_U = 8'h75;
   localparam logic [7:0] CH_DIG_0 = 8'h30;
   localparam logic [7:0] CH_DIG_9 = 8'h39;
   localparam logic [7:0] CH_LC_A = 8'h61;
   localparam logic [7:0] CH_UC_A = 8'h41;
   localparam logic [7:0] CH_UC_F = 8'h46;

   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_BRACES = 5'b00010,
      PH_STRING = 5'b00100,
      PH_ESCAPE = 5'b01000,
      PH_HEX    = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_MORE       = 2'd0,
      ST_DONE       = 2'd1,
      ST_ERROR      = 2'd2,
      ST_INCOMPLETE = 2'd3
   } status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_LC_A && c <= CH_LC_F) ||
             (c >= CH_UC_A && c <= CH_UC_F);
   endfunction

   function automatic logic is_escape_char(input logic [7:0] c);
      return c == CH_BSLASH || c == CH_QUOTE || c == CH_SLASH || c == CH_LC_B ||
             c == CH_LC_F || c == CH_LC_N || c == CH_LC_R || c == CH_LC_T ||
             c == CH_LC_U;
   endfunction

endpackage

// ===== design/json_message_boundary_splitter_top.sv =====
// Top level of the JSON message splitter: byte scanner, state and result register.
//
//  channel   | ports                              | direction
//  ----------+------------------------------------+----------
//  request   | req_valid, req_ready, req_ch       | in
//  result    | rsp_valid, rsp_ready, rsp_status,  | out
//            | rsp_consumed                       |
//
// Each request is scanned in the cycle it is accepted and its result appears in the
// result register on the next cycle; one request per cycle is sustained while results are taken.
// The result register is the only stage, so req_ready stays high while the result is
// taken or the register is empty, and drops only while a result is stalled.
// Reset clears the scan state to the start of a message and empties the result register.
module json_message_boundary_splitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_consumed
);

   jmbs_pkg::phase_type                 phase_ff, phase_in;
   logic [2:0]                          hex_left_ff, hex_left_in;
   logic [jmbs_pkg::DEPTH_BITS-1:0]     depth_count_ff, depth_count_in;
   logic [jmbs_pkg::LEN_BITS-1:0]       byte_count_ff, byte_count_in;
   logic [jmbs_pkg::LEN_BITS-1:0]       count_inc;
   logic [jmbs_pkg::LEN_BITS-1:0]       consumed_full;
   jmbs_pkg::status_type                status;

   logic                                rsp_valid_ff;
   jmbs_pkg::status_type                rsp_status_ff;
   logic [jmbs_pkg::CONSUMED_BITS-1:0]  rsp_consumed_ff;
   logic                                req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_consumed = rsp_consumed_ff;
   assign count_inc = byte_count_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      hex_left_in = hex_left_ff;
      depth_count_in = depth_count_ff;
      byte_count_in = byte_count_ff;
      consumed_full = byte_count_ff;
      status = jmbs_pkg::ST_MORE;
      if (req_ch == jmbs_pkg::CH_NUL) begin
         if (phase_ff == jmbs_pkg::PH_ESCAPE || phase_ff == jmbs_pkg::PH_HEX) begin
            status = jmbs_pkg::ST_ERROR;
         end else begin
            status = jmbs_pkg::ST_INCOMPLETE;
         end
      end else if (byte_count_ff == jmbs_pkg::LEN_MAX) begin
         status = jmbs_pkg::ST_ERROR;
      end else begin
         byte_count_in = count_inc;
         consumed_full = count_inc;
         case (phase_ff)
            jmbs_pkg::PH_BRACES: begin
               if (req_ch == jmbs_pkg::CH_OPEN) begin
                  if (depth_count_ff == jmbs_pkg::DEPTH_MAX) begin
                     status = jmbs_pkg::ST_ERROR;
                  end else begin
                     depth_count_in = depth_count_ff + 1'b1;
                  end
               end else if (req_ch == jmbs_pkg::CH_CLOSE) begin
                  if (depth_count_ff <= jmbs_pkg::DEPTH_BITS'(1)) begin
                     status = jmbs_pkg::ST_DONE;
                  end else begin
                     depth_count_in = depth_count_ff - 1'b1;
                  end
               end else if (req_ch == jmbs_pkg::CH_QUOTE) begin
                  phase_in = jmbs_pkg::PH_STRING;
               end
            end
            jmbs_pkg::PH_STRING: begin
               if (req_ch == jmbs_pkg::CH_QUOTE) begin
                  phase_in = jmbs_pkg::PH_BRACES;
               end else if (req_ch == jmbs_pkg::CH_BSLASH) begin
                  phase_in = jmbs_pkg::PH_ESCAPE;
               end
            end
            jmbs_pkg::PH_ESCAPE: begin
               if (!jmbs_pkg::is_escape_char(req_ch)) begin
                  status = jmbs_pkg::ST_ERROR;
               end else if (req_ch == jmbs_pkg::CH_LC_U) begin
                  hex_left_in = 3'(jmbs_pkg::HEX_DIGITS);
                  phase_in = jmbs_pkg::PH_HEX;
               end else begin
                  phase_in = jmbs_pkg::PH_STRING;
               end
            end
            jmbs_pkg::PH_HEX: begin
               if (!jmbs_pkg::is_hex(req_ch)) begin
                  status = jmbs_pkg::ST_ERROR;
               end else begin
                  hex_left_in = hex_left_ff - 1'b1;
                  if (hex_left_ff == 3'd1) begin
                     phase_in = jmbs_pkg::PH_STRING;
                  end
               end
            end
            default: begin
               if (req_ch != jmbs_pkg::CH_SPACE && req_ch != jmbs_pkg::CH_TAB) begin
                  if (req_ch != jmbs_pkg::CH_OPEN) begin
                     status = jmbs_pkg::ST_ERROR;
                  end else begin
                     depth_count_in = jmbs_pkg::DEPTH_BITS'(1);
                     phase_in = jmbs_pkg::PH_BRACES;
                  end
               end
            end
         endcase
      end
      if (status != jmbs_pkg::ST_MORE) begin
         phase_in = jmbs_pkg::PH_START;
         hex_left_in = '0;
         depth_count_in = '0;
         byte_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jmbs_pkg::PH_START;
         hex_left_ff <= '0;
         depth_count_ff <= '0;
         byte_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff <= phase_in;
            hex_left_ff <= hex_left_in;
            depth_count_ff <= depth_count_in;
            byte_count_ff <= byte_count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_status_ff <= status;
         rsp_consumed_ff <= jmbs_pkg::CONSUMED_BITS'(consumed_full);
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the JSON message splitter: directed table and random text.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jmbs_pkg::*;

   typedef struct packed {
      status_type                 status;
      logic [CONSUMED_BITS-1:0]   consumed;
   } framing_type;

   typedef struct packed {
      logic [7:0]  ch;
      bit          typed;
      framing_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_ch;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_consumed;

   json_message_boundary_splitter_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_consumed (rsp_consumed)
   );

   phase_type             scan_phase = PH_START;
   logic [2:0]            hex_due = '0;
   logic [DEPTH_BITS-1:0] nest_depth = '0;
   logic [LEN_BITS-1:0]   msg_len = '0;

   framing_type framing_q[$];
   framing_type oldest;
   logic [7:0]  text_q[$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;
   logic [15:0] stall_pattern = '1;
   int unsigned pattern_age = 0;
   string       escape_chars = "\\\"/bfnrt";
   string       hex_chars = "0123456789abcdefABCDEF";

   stim_row_type directed_rows [28] = '{
      '{8'h00, 1'b1, '{ST_INCOMPLETE, 16'd0}},
      '{" ",   1'b1, '{ST_MORE, 16'd1}},
      '{"\t",  1'b1, '{ST_MORE, 16'd2}},
      '{"{",   1'b1, '{ST_MORE, 16'd3}},
      '{"\"",  1'b0, '0},
      '{"}",   1'b0, '0},
      '{"\\",  1'b0, '0},
      '{"u",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"a",   1'b0, '0},
      '{"F",   1'b0, '0},
      '{"9",   1'b0, '0},
      '{"\"",  1'b0, '0},
      '{"{",   1'b0, '0},
      '{"}",   1'b0, '0},
      '{"}",   1'b1, '{ST_DONE, 16'd15}},
      '{8'hFF, 1'b1, '{ST_ERROR, 16'd1}},
      '{"{",   1'b0, '0},
      '{8'h00, 1'b1, '{ST_INCOMPLETE, 16'd1}},
      '{"{",   1'b0, '0},
      '{"\"",  1'b0, '0},
      '{"\\",  1'b0, '0},
      '{"x",   1'b1, '{ST_ERROR, 16'd4}},
      '{"{",   1'b0, '0},
      '{"\"",  1'b0, '0},
      '{"\\",  1'b0, '0},
      '{"u",   1'b0, '0},
      '{"g",   1'b1, '{ST_ERROR, 16'd5}}
   };

   always #6 clock = ~clock;

   function automatic framing_type predict_framing(input logic [7:0] ch);
      framing_type res;
      res.status = ST_MORE;
      if (ch == 8'h00) begin
         res.status = (scan_phase == PH_ESCAPE || scan_phase == PH_HEX) ? ST_ERROR
                                                                         : ST_INCOMPLETE;
      end else if (msg_len == '1) begin
         res.status = ST_ERROR;
      end else begin
         msg_len++;
         case (scan_phase)
            PH_BRACES: begin
               if (ch == "{") begin
                  if (nest_depth == '1) res.status = ST_ERROR;
                  else nest_depth++;
               end else if (ch == "}") begin
                  if (nest_depth <= 1) res.status = ST_DONE;
                  else nest_depth--;
               end else if (ch == "\"") begin
                  scan_phase = PH_STRING;
               end
            end
            PH_STRING: begin
               if (ch == "\"") scan_phase = PH_BRACES;
               else if (ch == "\\") scan_phase = PH_ESCAPE;
            end
            PH_ESCAPE: begin
               case (ch)
                  "\\", "\"", "/", "b", "f", "n", "r", "t": scan_phase = PH_STRING;
                  "u": begin
                     hex_due = 3'd4;
                     scan_phase = PH_HEX;
                  end
                  default: res.status = ST_ERROR;
               endcase
            end
            PH_HEX: begin
               if ((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
                   (ch >= "A" && ch <= "F")) begin
                  hex_due--;
                  if (hex_due == 3'd0) scan_phase = PH_STRING;
               end else begin
                  res.status = ST_ERROR;
               end
            end
            default: begin
               if (ch == "{") begin
                  nest_depth = DEPTH_BITS'(1);
                  scan_phase = PH_BRACES;
               end else if (ch != " " && ch != "\t") begin
                  res.status = ST_ERROR;
               end
            end
         endcase
      end
      res.consumed = msg_len[CONSUMED_BITS-1:0];
      if (res.status != ST_MORE) begin
         scan_phase = PH_START;
         hex_due = '0;
         nest_depth = '0;
         msg_len = '0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic drive_request(input logic [7:0] ch, input bit typed,
                                input framing_type want);
      framing_type guess;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_ch <= ch;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      guess = predict_framing(ch);
      framing_q.push_back(typed ? want : guess);
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      burst_left = 0;
      while (framing_q.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (framing_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived", framing_q.size()));
         framing_q.delete();
      end
   endtask

   task automatic build_object(input int unsigned max_depth);
      int unsigned level;
      int unsigned steps;
      int unsigned choice;
      logic [7:0]  b;
      repeat ($urandom_range(0, 3)) text_q.push_back(($urandom_range(0, 1) != 0) ? " " : "\t");
      level = $urandom_range(1, max_depth);
      repeat (level) text_q.push_back("{");
      steps = 0;
      while (level != 0) begin
         steps++;
         choice = (steps > 40) ? 3 : $urandom_range(0, 9);
         case (choice)
            0, 1, 2: begin
               if (level < max_depth) begin
                  text_q.push_back("{");
                  level++;
               end
            end
            3, 4: begin
               text_q.push_back("}");
               level--;
            end
            5, 6: begin
               text_q.push_back("\"");
               repeat ($urandom_range(0, 6)) begin
                  case ($urandom_range(0, 5))
                     0: begin
                        text_q.push_back("\\");
                        text_q.push_back(escape_chars[$urandom_range(0, 7)]);
                     end
                     1: begin
                        text_q.push_back("\\");
                        text_q.push_back("u");
                        repeat (4) text_q.push_back(hex_chars[$urandom_range(0, 21)]);
                     end
                     default: begin
                        b = 8'($urandom_range(1, 255));
                        if (b == "\"" || b == "\\") b = "{";
                        text_q.push_back(b);
                     end
                  endcase
               end
               text_q.push_back("\"");
            end
            default: begin
               b = 8'($urandom_range(1, 255));
               if (b == "{" || b == "}" || b == "\"") b = " ";
               text_q.push_back(b);
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (pattern_age == 0) begin
         pattern_age <= $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hFFFF;
            1: stall_pattern <= 16'($urandom) | 16'h0101;
            2: stall_pattern <= 16'hAAAA;
            default: stall_pattern <= (16'($urandom) & 16'($urandom)) | 16'h8000;
         endcase
      end else begin
         pattern_age <= pattern_age - 1;
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      end
      rsp_ready <= stall_pattern[15];
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (framing_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d consumed %0d",
                                      rsp_status, rsp_consumed));
         end else begin
            oldest = framing_q.pop_front();
            if (rsp_status !== oldest.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status,
                                         oldest.status));
            if (rsp_consumed !== oldest.consumed)
               report_mismatch($sformatf("consumed %0d, expected %0d", rsp_consumed,
                                         oldest.consumed));
         end
      end
   end

   initial begin
      int unsigned random_sent;
      int unsigned cut;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_request(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      random_sent = 0;
      while (random_sent < 1200) begin
         text_q.delete();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
               build_object(($urandom_range(0, 14) == 0) ? 300 : 6);
               if ($urandom_range(0, 7) == 0) text_q.push_back(8'h00);
            end
            14, 15, 16, 17: begin
               build_object(6);
               cut = $urandom_range(1, text_q.size() - 1);
               while (text_q.size() > cut) void'(text_q.pop_back());
               case ($urandom_range(0, 2))
                  0: text_q.push_back(8'h00);
                  1: text_q.push_back(8'($urandom_range(0, 255)));
                  default: text_q.push_back("g");
               endcase
            end
            default: begin
               repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            end
         endcase
         foreach (text_q[i]) drive_request(text_q[i], 1'b0, '0);
         random_sent += text_q.size();
         if ($urandom_range(0, 40) == 0) drain_results();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
design/jmbs_pkg.sv
design/json_message_boundary_splitter_top.sv
tb/tb_top.sv
